@@ hdl/go_to_point_steering_core_macros.svh @@
// Assertion macros shared by the go-to-point steering RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GO_TO_POINT_STEERING_CORE_MACROS_SVH
`define GO_TO_POINT_STEERING_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GTPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define GTPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gtps_pkg.sv @@
// Shared types, constants and CORDIC helpers for the go-to-point steering core.
// No dependencies; imported by every module of the block.
`default_nettype none

package gtps_pkg;

  // CORDIC sizing
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int CW   = 28;  // x/y datapath: 17-bit delta << 8, plus CORDIC growth
  localparam int AW   = 32;  // angle accumulator, 2^32 per turn

  typedef enum logic [1:0] {
    CMD_STOP    = 2'd0,
    CMD_LEFT    = 2'd1,
    CMD_RIGHT   = 2'd2,
    CMD_FORWARD = 2'd3
  } steer_cmd_t;

  typedef enum logic [1:0] {
    REG_TARGET_X = 2'd0,
    REG_TARGET_Y = 2'd1,
    REG_MOVE_TOL = 2'd2,
    REG_TURN_TOL = 2'd3
  } cfg_reg_t;

  // Configuration register file contents
  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [14:0]        move_tol;
    logic [14:0]        turn_tol;
  } gtps_cfg_t;

  // One request in flight through queue and CORDIC
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [AW-1:0]        acc;
    logic [15:0]          heading;
    logic                 stop;
    logic                 zero;
  } gtps_item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } gtps_q_stat_t;

  // atan(2^-i) in 2^32-per-turn units, rounded to nearest
  function automatic logic [AW-1:0] atan_turn(input int unsigned idx);
    logic [AW-1:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One vectoring iteration; idx is a constant at every call site
  function automatic gtps_item_t cordic_step(input gtps_item_t s, input int unsigned idx);
    gtps_item_t           r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    r  = s;
    xs = s.x >>> idx;
    ys = s.y >>> idx;
    if (!s.y[CW-1] && (s.y != '0)) begin
      r.x   = s.x + ys;
      r.y   = s.y - xs;
      r.acc = s.acc + atan_turn(idx);
    end else begin
      r.x   = s.x - ys;
      r.y   = s.y + xs;
      r.acc = s.acc - atan_turn(idx);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/gtps_front.sv @@
// Front end: takes a pose request, forms the target deltas, classifies stop and
// zero-vector cases and pre-rotates the vector into the right half plane.
// Depends on gtps_pkg.
`default_nettype none

module gtps_front
  import gtps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic [15:0]        heading,
  input  wire gtps_cfg_t          cfg,
  output logic                    push,
  output gtps_item_t              item
);

  logic                 vld_r;
  gtps_item_t           item_r;
  gtps_item_t           item_nxt;
  logic signed [16:0]   dx;
  logic signed [16:0]   dy;
  logic [16:0]          adx;
  logic [16:0]          ady;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;

  // Deltas and classification
  always_comb begin
    dx  = 17'(cfg.target_x) - 17'(pos_x);
    dy  = 17'(cfg.target_y) - 17'(pos_y);
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    x0  = {{(CW-25){dx[16]}}, dx, 8'h00};
    y0  = {{(CW-25){dy[16]}}, dy, 8'h00};

    item_nxt.heading = heading;
    item_nxt.stop    = (adx < {2'b00, cfg.move_tol}) && (ady < {2'b00, cfg.move_tol});
    item_nxt.zero    = (dx == '0) && (dy == '0);
    // left half plane: turn by half a turn first
    if (dx[16]) begin
      item_nxt.x   = -x0;
      item_nxt.y   = -y0;
      item_nxt.acc = 32'h80000000;
    end else begin
      item_nxt.x   = x0;
      item_nxt.y   = y0;
      item_nxt.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push = vld_r;
  assign item = item_r;

endmodule

`default_nettype wire

@@ hdl/gtps_queue.sv @@
// Two-entry request queue decoupling the front end from the CORDIC back end.
// Depends on gtps_pkg and the assertion macro header.
`default_nettype none
`include "go_to_point_steering_core_macros.svh"

module gtps_queue
  import gtps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire gtps_item_t wr_item,
  input  wire logic       pop,
  output gtps_item_t      rd_item,
  output gtps_q_stat_t    stat
);

  gtps_item_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

  `GTPS_ASSERT_NOW(a_no_overflow, clk, rst_n, push && !pop, count_r != 2'd2, "queue overflow")
  `GTPS_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, count_r != 2'd0, "queue underflow")
  `GTPS_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 2'd1, "count did not grow")

endmodule

`default_nettype wire

@@ hdl/gtps_back.sv @@
// Back end: unrolled CORDIC vectoring pipeline, one iteration per stage, then
// the steering decision register. Depends on gtps_pkg and the macro header.
`default_nettype none
`include "go_to_point_steering_core_macros.svh"

module gtps_back
  import gtps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire gtps_q_stat_t q_stat,
  input  wire gtps_item_t  q_item,
  input  wire logic [14:0] turn_tol,
  output logic             pop,
  output logic             out_valid,
  output steer_cmd_t       out_cmd,
  output logic [15:0]      out_bearing
);

  gtps_item_t    stg_r     [0:NSTG];
  logic          stg_vld_r [0:NSTG];
  logic          out_valid_r;
  steer_cmd_t    out_cmd_r;
  steer_cmd_t    cmd_nxt;
  logic [15:0]   out_bearing_r;
  logic [15:0]   bearing_nxt;
  logic [AW-1:0] acc_rnd;
  logic [15:0]   ccw;
  logic [15:0]   cw;
  logic [15:0]   gap_min;

  // Back end never stalls: drain the queue whenever it holds a request
  assign pop = !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r[0] <= 1'b0;
    end else begin
      stg_vld_r[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      stg_r[0] <= q_item;
    end
  end

  // CORDIC stages
  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_vld_r[i+1] <= 1'b0;
      end else begin
        stg_vld_r[i+1] <= stg_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      stg_r[i+1] <= cordic_step(stg_r[i], i);
    end
  end

  // Round bearing, pick steering command
  always_comb begin
    acc_rnd = stg_r[NSTG].acc + 32'h00008000;
    bearing_nxt = stg_r[NSTG].zero ? 16'h0000 : acc_rnd[AW-1:AW-16];
    ccw     = bearing_nxt - stg_r[NSTG].heading;
    cw      = stg_r[NSTG].heading - bearing_nxt;
    gap_min = (ccw < cw) ? ccw : cw;
    if (stg_r[NSTG].stop) begin
      cmd_nxt     = CMD_STOP;
      bearing_nxt = 16'h0000;
    end else if (gap_min < {1'b0, turn_tol}) begin
      cmd_nxt = CMD_FORWARD;
    end else if (ccw < cw) begin
      cmd_nxt = CMD_LEFT;
    end else begin
      cmd_nxt = CMD_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_vld_r[NSTG]) begin
      out_cmd_r     <= cmd_nxt;
      out_bearing_r <= bearing_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cmd     = out_cmd_r;
  assign out_bearing = out_bearing_r;

  `GTPS_ASSERT_NEXT(a_pop_enters, clk, rst_n, pop, stg_vld_r[0], "popped request lost")
  `GTPS_ASSERT_NEXT(a_last_stage_out, clk, rst_n, stg_vld_r[NSTG], out_valid_r, "result dropped")
  `GTPS_ASSERT_NOW(a_stop_zero, clk, rst_n, out_valid_r && (out_cmd_r == CMD_STOP), out_bearing_r == 16'h0000, "stop with bearing")

endmodule

`default_nettype wire

@@ hdl/go_to_point_steering_core.sv @@
// Top level of the go-to-point steering core: configuration registers and the
// front end / queue / CORDIC back end. Depends on gtps_pkg and gtps_* modules.
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+--------------------------
//   input   | in_pos_x, in_pos_y, in_heading             | start & !busy
//   result  | out_steer_cmd, out_bearing                 | out_valid, one cycle
//   config  | cfg_index, cfg_data                        | cfg_valid & cfg_ready
//
// One request per cycle is accepted; each result passes through the front register,
// the queue entry, the back-end input register, each CORDIC stage register and the
// decision register. The unrolled CORDIC pipeline takes one request per cycle.
// Reset is synchronous, active low; it clears control state and loads register
// defaults. The receiver cannot stall and the back end pops the queue whenever
// it holds a request, so the queue never fills and busy stays low.
`default_nettype none

module go_to_point_steering_core
  import gtps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic [15:0]        in_heading,
  // result channel
  output logic                    out_valid,
  output logic [1:0]              out_steer_cmd,
  output logic [15:0]             out_bearing,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  gtps_cfg_t    cfg_r;
  logic         accept;
  logic         push;
  logic         pop;
  gtps_item_t   f_item;
  gtps_item_t   q_item;
  gtps_q_stat_t q_stat;
  steer_cmd_t   cmd;

  assign cfg_ready = 1'b1;
  assign busy      = q_stat.full;
  assign accept    = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_x <= '0;
      cfg_r.target_y <= '0;
      cfg_r.move_tol <= 15'd13;
      cfg_r.turn_tol <= 15'd522;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_X: cfg_r.target_x <= cfg_data;
        REG_TARGET_Y: cfg_r.target_y <= cfg_data;
        REG_MOVE_TOL: cfg_r.move_tol <= cfg_data[14:0];
        REG_TURN_TOL: cfg_r.turn_tol <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  gtps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .heading (in_heading),
    .cfg     (cfg_r),
    .push    (push),
    .item    (f_item)
  );

  gtps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (f_item),
    .pop     (pop),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  gtps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_item      (q_item),
    .turn_tol    (cfg_r.turn_tol),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_cmd     (cmd),
    .out_bearing (out_bearing)
  );

  assign out_steer_cmd = cmd;

endmodule

`default_nettype wire
